FILE: sv/sbda_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and helpers for the signed binary to decimal ascii converter
package sbda_pkg;

    // default integer width of a request
    localparam int DATA_WIDTH_DEF = 32;

    // the divide unit consumes the magnitude one byte at a time
    localparam int CHUNK_W = 8;

    // remainder of a divide by ten fits in four bits
    localparam int DIGIT_W = 4;

    // character codes
    localparam logic [7:0] ASCII_ZERO  = 8'd48;
    localparam logic [7:0] ASCII_MINUS = 8'd45;

    // scaled reciprocal of ten (2^16 / 10, rounded up)
    localparam logic [12:0] RECIP_TEN   = 13'd6554;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } state_t;

    // decimal digits of the largest magnitude, 2^(w-1)
    function automatic int dec_digits(input int w);
        return ((w - 1) * 30103) / 100000 + 1;
    endfunction

endpackage

FILE: sv/sbda_div10_step.sv
`timescale 1ns / 1ps
// one long-division step by ten: running remainder and one byte in, quotient byte and remainder out
module sbda_div10_step (
    input  logic [sbda_pkg::DIGIT_W-1:0] rem_in,
    input  logic [sbda_pkg::CHUNK_W-1:0] data_in,
    output logic [sbda_pkg::CHUNK_W-1:0] quo_out,
    output logic [sbda_pkg::DIGIT_W-1:0] rem_out
);

    localparam int XW = sbda_pkg::DIGIT_W + sbda_pkg::CHUNK_W;
    localparam int PW = XW + 13;

    logic [XW-1:0] dividend;
    logic [PW-1:0] product;
    logic [XW-1:0] back;
    logic [XW-1:0] diff;

    // dividend stays below 160 * 16, so the reciprocal estimate is exact
    assign dividend = {rem_in, data_in};
    assign product  = PW'(dividend) * PW'(sbda_pkg::RECIP_TEN);
    assign quo_out  = product[16 +: sbda_pkg::CHUNK_W];

    // remainder from quotient times ten
    assign back    = XW'({quo_out, 3'b000}) + XW'({quo_out, 1'b0});
    assign diff    = dividend - back;
    assign rem_out = diff[sbda_pkg::DIGIT_W-1:0];

endmodule

FILE: sv/sbda_digit_store.sv
`timescale 1ns / 1ps
// generic ram with one write port and one registered read port
module sbda_digit_store #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 10
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [$clog2(DEPTH)-1:0]     wr_addr,
    input  logic [WIDTH-1:0]             wr_data,
    input  logic [$clog2(DEPTH)-1:0]     rd_addr,
    output logic [WIDTH-1:0]             rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // registered read port, a write to the same address passes straight through
    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_data_reg <= wr_data;
        end
        else
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/signed_binary_to_decimal_ascii_top.sv
`timescale 1ns / 1ps
// top level of the signed binary to decimal ascii converter
// CHUNKS = ceil(DATA_WIDTH / 8) byte steps per digit go through the shared byte divider,
//   then the characters are emitted one per cycle
// a new request is taken only in idle, once the previous text has been fully registered
// busy is high from the cycle after start until the last character is registered
// the receiver cannot stall: each character is shown for one cycle with strobe high
// reset (rst_n low, asynchronous) returns the sequencer to idle and clears strobe
module signed_binary_to_decimal_ascii_top #(
    parameter int DATA_WIDTH = sbda_pkg::DATA_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [DATA_WIDTH-1:0] value,
    output logic                         busy,
    output logic                         strobe,
    output logic [7:0]                   ascii_char,
    output logic                         last
);

    localparam int CW_BYTE = sbda_pkg::CHUNK_W;
    localparam int CHUNKS  = (DATA_WIDTH + CW_BYTE - 1) / CW_BYTE;
    localparam int QW      = CHUNKS * CW_BYTE;
    localparam int DIGITS  = sbda_pkg::dec_digits(DATA_WIDTH);
    localparam int AW      = $clog2(DIGITS);
    localparam int CW      = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

    sbda_pkg::state_t state_reg, state_next;

    logic [QW-1:0]                  quotient_reg, quotient_next;
    logic [sbda_pkg::DIGIT_W-1:0]   rem_reg, rem_next;
    logic [CW-1:0]                  chunk_reg, chunk_next;
    logic [AW-1:0]                  dcnt_reg, dcnt_next;
    logic [AW-1:0]                  idx_reg, idx_next;
    logic                           sign_reg, sign_next;
    logic                           strobe_reg, strobe_next;
    logic [7:0]                     char_reg, char_next;
    logic                           last_reg, last_next;

    logic                           load;
    logic                           div_en;
    logic                           emit_en;
    logic [DATA_WIDTH-1:0]          value_u;
    logic [DATA_WIDTH-1:0]          magnitude;
    logic [CW_BYTE-1:0]             quo_byte;
    logic [sbda_pkg::DIGIT_W-1:0]   step_rem;
    logic [QW-1:0]                  shifted_q;
    logic                           last_chunk;
    logic                           q_zero;
    logic                           store_we;
    logic [sbda_pkg::DIGIT_W-1:0]   rd_digit;
    logic                           emit_done;

    // unsigned magnitude, correct for the most negative value too
    assign value_u   = value;
    assign magnitude = value_u[DATA_WIDTH-1] ? (~value_u + 1'b1) : value_u;

    // shared byte divider on the top byte of the running quotient
    sbda_div10_step u_div (
        .rem_in  (rem_reg),
        .data_in (quotient_reg[QW-1 -: CW_BYTE]),
        .quo_out (quo_byte),
        .rem_out (step_rem)
    );

    assign shifted_q  = (quotient_reg << CW_BYTE) | QW'(quo_byte);
    assign last_chunk = (chunk_reg == CW'(CHUNKS - 1));
    assign q_zero     = (shifted_q == '0);
    assign store_we   = div_en && last_chunk;
    assign emit_done  = !sign_reg && (idx_reg == '0);

    // remainder store, addressed with the next index so the digit is ready when its character is formed
    sbda_digit_store #(
        .WIDTH (sbda_pkg::DIGIT_W),
        .DEPTH (DIGITS)
    ) u_store (
        .clk     (clk),
        .wr_en   (store_we),
        .wr_addr (dcnt_reg),
        .wr_data (step_rem),
        .rd_addr (idx_next),
        .rd_data (rd_digit)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sbda_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = sbda_pkg::ST_DIV;
                end
            end
            sbda_pkg::ST_DIV:
            begin
                if (last_chunk && q_zero)
                begin
                    state_next = sbda_pkg::ST_EMIT;
                end
            end
            sbda_pkg::ST_EMIT:
            begin
                if (emit_done)
                begin
                    state_next = sbda_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sbda_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        load    = 1'b0;
        div_en  = 1'b0;
        emit_en = 1'b0;
        busy    = 1'b1;
        unique case (state_reg)
            sbda_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                load = start;
            end
            sbda_pkg::ST_DIV:
            begin
                div_en = 1'b1;
            end
            sbda_pkg::ST_EMIT:
            begin
                emit_en = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        quotient_next = quotient_reg;
        rem_next      = rem_reg;
        chunk_next    = chunk_reg;
        dcnt_next     = dcnt_reg;
        idx_next      = idx_reg;
        sign_next     = sign_reg;
        strobe_next   = 1'b0;
        char_next     = char_reg;
        last_next     = last_reg;

        if (load)
        begin
            quotient_next = QW'(magnitude);
            rem_next      = '0;
            chunk_next    = '0;
            dcnt_next     = '0;
            sign_next     = value_u[DATA_WIDTH-1];
        end

        // one byte of long division per cycle, one digit per pass
        if (div_en)
        begin
            quotient_next = shifted_q;
            if (last_chunk)
            begin
                rem_next   = '0;
                chunk_next = '0;
                if (q_zero)
                begin
                    idx_next = dcnt_reg;
                end
                else
                begin
                    dcnt_next = dcnt_reg + 1'b1;
                end
            end
            else
            begin
                rem_next   = step_rem;
                chunk_next = chunk_reg + 1'b1;
            end
        end

        // sign first, then digits most significant first
        if (emit_en)
        begin
            strobe_next = 1'b1;
            if (sign_reg)
            begin
                sign_next = 1'b0;
                char_next = sbda_pkg::ASCII_MINUS;
                last_next = 1'b0;
            end
            else
            begin
                idx_next  = idx_reg - 1'b1;
                char_next = sbda_pkg::ASCII_ZERO + {4'b0000, rd_digit};
                last_next = (idx_reg == '0);
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= sbda_pkg::ST_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        quotient_reg <= quotient_next;
        rem_reg      <= rem_next;
        chunk_reg    <= chunk_next;
        dcnt_reg     <= dcnt_next;
        idx_reg      <= idx_next;
        sign_reg     <= sign_next;
        char_reg     <= char_next;
        last_reg     <= last_next;
    end

    assign strobe     = strobe_reg;
    assign ascii_char = char_reg;
    assign last       = last_reg;

endmodule

FILE: sv/sbda_checker.sv
`timescale 1ns / 1ps
// port-level checker for the converter, bound to the top level
module sbda_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       strobe,
    input logic [7:0] ascii_char,
    input logic       last
);

    // characters of one request come in an unbroken run
    a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last) |=> strobe)
        else $error("character run broken before last");

    // nothing follows the last character directly
    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |=> !strobe)
        else $error("strobe right after last character");

    // converter is free again when the last character is shown
    a_idle_at_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |-> !busy)
        else $error("busy still high at last character");

    // an accepted request makes the block busy, with no character shown yet
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !strobe))
        else $error("request accepted but block not busy");

    // only minus sign or decimal digits are produced
    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (ascii_char == 8'd45 || (ascii_char >= 8'd48 && ascii_char <= 8'd57)))
        else $error("illegal output character");

endmodule

bind signed_binary_to_decimal_ascii_top sbda_checker u_sbda_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .strobe     (strobe),
    .ascii_char (ascii_char),
    .last       (last)
);

FILE: dv/tb_signed_binary_to_decimal_ascii_top.sv
`timescale 1ns / 1ps
// self-checking testbench for the signed binary to decimal ascii converter
module tb_signed_binary_to_decimal_ascii_top;

    localparam int WIDTH         = 32;
    localparam int DIRECTED_N    = 20;
    localparam int RANDOM_N      = 450;
    localparam int SETTLE_CYCLES = 60;
    localparam int DRAIN_LIMIT   = 4000;

    // one character of decimal text
    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } text_char_t;

    // predicts the decimal text of each request and checks the characters that come out
    class decimal_text_board;
        text_char_t expected_chars[$];
        int         failures;

        function new();
            failures = 0;
        endfunction

        // spell the value as digits, after a '-' if negative, most significant first
        function void note_request(logic [WIDTH-1:0] v);
            logic [WIDTH-1:0] magnitude;
            logic [3:0]       digits[$];
            text_char_t       c;
            magnitude = v[WIDTH-1] ? (~v + 1'b1) : v;
            do
            begin
                digits.push_front(4'(magnitude % 10));
                magnitude = magnitude / 10;
            end
            while (magnitude != 0);
            if (v[WIDTH-1])
            begin
                c.code = sbda_pkg::ASCII_MINUS;
                c.last = 1'b0;
                expected_chars.push_back(c);
            end
            foreach (digits[i])
            begin
                c.code = sbda_pkg::ASCII_ZERO + 8'(digits[i]);
                c.last = (i == digits.size() - 1);
                expected_chars.push_back(c);
            end
        endfunction

        // compare one emitted character with the oldest expected one
        function void check_char(logic [7:0] code, logic last);
            text_char_t want;
            if (expected_chars.size() == 0)
            begin
                $display("%0t: unexpected character: expected none, got char %0d last %0b",
                         $time, code, last);
                failures++;
                return;
            end
            want = expected_chars.pop_front();
            if (code !== want.code)
            begin
                $display("%0t: ascii_char mismatch: expected %0d, got %0d",
                         $time, want.code, code);
                failures++;
            end
            if (last !== want.last)
            begin
                $display("%0t: last mismatch: expected %0b, got %0b", $time, want.last, last);
                failures++;
            end
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction
    endclass

    logic             clk   = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic [WIDTH-1:0] value = '0;
    logic             busy;
    logic             strobe;
    logic [7:0]       ascii_char;
    logic             last;

    decimal_text_board board = new();
    bit                burst_mode = 1'b0;

    signed_binary_to_decimal_ascii_top #(
        .DATA_WIDTH(WIDTH)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .value     (value),
        .busy      (busy),
        .strobe    (strobe),
        .ascii_char(ascii_char),
        .last      (last)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // character monitor, samples pre-edge values
    always @(posedge clk)
    begin
        if (rst_n && strobe)
            board.check_char(ascii_char, last);
    end

    // watchdog
    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic longint unsigned ten_to(int k);
        longint unsigned p;
        p = 1;
        repeat (k) p = p * 10;
        return p;
    endfunction

    // random value: full range, a given digit count, near powers of ten, or near the extremes
    function automatic logic [WIDTH-1:0] random_value();
        int unsigned     pick;
        int              ndig;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mag;
        bit              neg;
        pick = $urandom_range(0, 9);
        neg  = $urandom_range(0, 1);
        if (pick < 3)
            return $urandom();
        if (pick < 7)
        begin
            ndig = $urandom_range(1, 10);
            lo   = (ndig == 1) ? 0 : ten_to(ndig - 1);
            hi   = ten_to(ndig) - 1;
            if (hi > 64'd2147483648)
                hi = 64'd2147483648;
            mag = lo + ($urandom() % (hi - lo + 1));
        end
        else if (pick < 9)
            mag = ten_to($urandom_range(0, 9)) + $urandom_range(0, 2) - 1;
        else
            mag = 64'd2147483648 - $urandom_range(0, 3);
        if (!neg && mag == 64'd2147483648)
            mag = mag - 1;
        return neg ? (~mag[WIDTH-1:0] + 1'b1) : mag[WIDTH-1:0];
    endfunction

    // wait until every expected character has come, bounded
    task automatic wait_drained(input int limit);
        int n;
        n = 0;
        do
        begin
            @(posedge clk);
            n++;
        end
        while (board.pending() != 0 && n < limit);
    endtask

    // present one request and hold it until accepted
    task automatic send_request(input logic [WIDTH-1:0] v, input bit drain);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 6);
        if (gap > 0 || drain)
        begin
            start <= 1'b0;
            if (drain)
                wait_drained(DRAIN_LIMIT);
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        value <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.note_request(v);
    endtask

    // stimulus
    initial
    begin
        logic [WIDTH-1:0] directed[DIRECTED_N];
        directed = '{
            32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10,
            32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'h7FFF_FFFE,
            32'd99, 32'd100, 32'd999999999, 32'd1000000000,
            -32'sd1000000000, -32'sd999999999, 32'd12345, -32'sd7,
            32'hAAAA_AAAA, 32'h5555_5555
        };

        // hold reset, then release it
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed extremes and edge cases
        foreach (directed[i])
            send_request(directed[i], 1'b0);

        // random part, with bursts and a few full drains
        for (int i = 0; i < RANDOM_N; i++)
        begin
            if (i % 50 == 0)
                burst_mode = ($urandom_range(0, 3) == 0);
            send_request(random_value(), (i == 0) || (i % 150 == 75));
        end

        // drain and let the block settle
        start <= 1'b0;
        wait_drained(DRAIN_LIMIT);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (board.pending() != 0)
            $display("%0t: %0d expected characters never came", $time, board.pending());
        if (board.failures == 0 && board.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
